// ----- design/bsm_pkg.sv -----
// Package for the bank switch mapper: item and state types, op codes and
// configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package bsm_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_PRG   = 2'd1,
        OP_CHR   = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic CFG_PRG_BANK_COUNT = 1'b0;
    localparam logic CFG_FOUR_SCREEN    = 1'b1;

    localparam logic [6:0] PRG_BANK_COUNT_RESET = 7'd32;
    localparam logic [6:0] PRG_BANK_COUNT_MIN   = 7'd2;
    localparam logic [6:0] PRG_BANK_COUNT_MAX   = 7'd64;

    // Register window, picked by address bits 14..13 above 8000
    localparam logic [1:0] WIN_SELECT = 2'd0;
    localparam logic [1:0] WIN_MIRROR = 2'd1;
    localparam logic [1:0] WIN_LATCH  = 2'd2;
    localparam logic [1:0] WIN_ENABLE = 2'd3;

    localparam logic [1:0] PRG_SLOT_LAST = 2'd3;
    localparam logic [1:0] PRG_SLOT_R7   = 2'd1;
    localparam logic [1:0] PRG_SLOT_ZERO = 2'd0;

    typedef struct packed {
        op_t         op;
        logic [15:0] address;
        logic [7:0]  write_data;
    } item_t;

    // Mapper state as seen by the address translation
    typedef struct packed {
        logic [7:0][7:0] bank_regs;
        logic            prg_invert;
        logic            chr_invert;
        logic [6:0]      prg_bank_count;
    } map_view_t;

endpackage

// ----- design/bsm_regs.sv -----
// Mapper register file, configuration registers and scanline IRQ counter.
// Depends on bsm_pkg.
`timescale 1ns / 1ps

module bsm_regs
    import bsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_valid,
    input  logic      cfg_index,
    input  logic [6:0] cfg_data,
    input  logic      advance,
    input  item_t     item,
    output map_view_t view,
    output logic      mirror_next,
    output logic      irq_next
);

    logic [7:0][7:0] bank_regs_reg, bank_regs_next;
    logic [2:0]      bank_select_reg, bank_select_next;
    logic            prg_invert_reg, prg_invert_next;
    logic            chr_invert_reg, chr_invert_next;
    logic            mirror_reg;
    logic [7:0]      irq_latch_reg, irq_latch_next;
    logic [7:0]      irq_count_reg, irq_count_next;
    logic            reload_reg, reload_next;
    logic            irq_enabled_reg, irq_enabled_next;
    logic            irq_reg;
    logic [6:0]      prg_bank_count_reg;
    logic            four_screen_reg;
    logic            odd;

    assign odd = item.address[0];

    always_comb
    begin
        bank_regs_next   = bank_regs_reg;
        bank_select_next = bank_select_reg;
        prg_invert_next  = prg_invert_reg;
        chr_invert_next  = chr_invert_reg;
        mirror_next      = mirror_reg;
        irq_latch_next   = irq_latch_reg;
        irq_count_next   = irq_count_reg;
        reload_next      = reload_reg;
        irq_enabled_next = irq_enabled_reg;
        irq_next         = irq_reg;
        case (item.op)
            OP_WRITE:
            begin
                // Below 8000 the mapper does not decode
                if (item.address[15])
                begin
                    case (item.address[14:13])
                        WIN_SELECT:
                        begin
                            if (!odd)
                            begin
                                bank_select_next = item.write_data[2:0];
                                prg_invert_next  = item.write_data[6];
                                chr_invert_next  = item.write_data[7];
                            end
                            else
                            begin
                                bank_regs_next[bank_select_reg] = item.write_data;
                            end
                        end
                        WIN_MIRROR:
                        begin
                            if (!odd && !four_screen_reg)
                                mirror_next = item.write_data[0];
                        end
                        WIN_LATCH:
                        begin
                            if (!odd)
                                irq_latch_next = item.write_data;
                            else
                                reload_next = 1'b1;
                        end
                        WIN_ENABLE:
                        begin
                            if (!odd)
                            begin
                                irq_enabled_next = 1'b0;
                                irq_next         = 1'b0;
                            end
                            else
                            begin
                                irq_enabled_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            OP_TICK:
            begin
                if (irq_count_reg == 8'd0 || reload_reg)
                begin
                    irq_count_next = irq_latch_reg;
                    reload_next    = 1'b0;
                end
                else
                begin
                    irq_count_next = irq_count_reg - 8'd1;
                end
                if (irq_count_next == 8'd0 && irq_enabled_reg)
                    irq_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_regs_reg   <= '0;
            bank_select_reg <= '0;
            prg_invert_reg  <= 1'b0;
            chr_invert_reg  <= 1'b0;
            mirror_reg      <= 1'b0;
            irq_latch_reg   <= '0;
            irq_count_reg   <= '0;
            reload_reg      <= 1'b0;
            irq_enabled_reg <= 1'b0;
            irq_reg         <= 1'b0;
        end
        else if (advance)
        begin
            bank_regs_reg   <= bank_regs_next;
            bank_select_reg <= bank_select_next;
            prg_invert_reg  <= prg_invert_next;
            chr_invert_reg  <= chr_invert_next;
            mirror_reg      <= mirror_next;
            irq_latch_reg   <= irq_latch_next;
            irq_count_reg   <= irq_count_next;
            reload_reg      <= reload_next;
            irq_enabled_reg <= irq_enabled_next;
            irq_reg         <= irq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_bank_count_reg <= PRG_BANK_COUNT_RESET;
            four_screen_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PRG_BANK_COUNT: prg_bank_count_reg <= cfg_data;
                CFG_FOUR_SCREEN:    four_screen_reg    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign view.bank_regs      = bank_regs_reg;
    assign view.prg_invert     = prg_invert_reg;
    assign view.chr_invert     = chr_invert_reg;
    assign view.prg_bank_count = prg_bank_count_reg;

endmodule

// ----- design/bsm_xlate.sv -----
// PRG and CHR address translation from the current bank registers.
// Depends on bsm_pkg.
`timescale 1ns / 1ps

module bsm_xlate
    import bsm_pkg::*;
(
    input  item_t       item,
    input  map_view_t   view,
    output logic [18:0] rom_offset
);

    logic [6:0] count;
    logic [5:0] last_bank;
    logic [5:0] second_bank;
    logic [5:0] prg_bank;
    logic [1:0] prg_slot;
    logic [2:0] chr_slot;
    logic [2:0] chr_index;
    logic [7:0] chr_bank;
    logic [18:0] prg_offset;
    logic [18:0] chr_offset;

    // Clamp the bank count to 2..64 before deriving the fixed banks
    always_comb
    begin
        if (view.prg_bank_count < PRG_BANK_COUNT_MIN)
            count = PRG_BANK_COUNT_MIN;
        else if (view.prg_bank_count > PRG_BANK_COUNT_MAX)
            count = PRG_BANK_COUNT_MAX;
        else
            count = view.prg_bank_count;
    end

    assign last_bank   = 6'(count - 7'd1);
    assign second_bank = 6'(count - 7'd2);
    assign prg_slot    = item.address[14:13];

    always_comb
    begin
        if (prg_slot == PRG_SLOT_LAST)
            prg_bank = last_bank;
        else if (prg_slot == PRG_SLOT_R7)
            prg_bank = view.bank_regs[7][5:0];
        else if ((prg_slot == PRG_SLOT_ZERO) != view.prg_invert)
            prg_bank = view.bank_regs[6][5:0];
        else
            prg_bank = second_bank;
    end

    assign prg_offset = item.address[15] ? {prg_bank, item.address[12:0]} : '0;

    assign chr_slot  = item.address[12:10] ^ {view.chr_invert, 2'b00};
    assign chr_index = chr_slot - 3'd2;

    always_comb
    begin
        if (!chr_slot[2])
            chr_bank = {view.bank_regs[{2'b00, chr_slot[1]}][7:1], chr_slot[0]};
        else
            chr_bank = view.bank_regs[chr_index];
    end

    assign chr_offset = {1'b0, chr_bank, item.address[9:0]};

    always_comb
    begin
        case (item.op)
            OP_PRG:  rom_offset = prg_offset;
            OP_CHR:  rom_offset = chr_offset;
            default: rom_offset = '0;
        endcase
    end

endmodule

// ----- design/bank_switch_mapper_with_scanline_irq.sv -----
// Channel  | dir | payload
// s_axis   | in  | tuser: op; tdata: address, write_data
// m_axis   | out | tdata: rom_offset, mirror_horizontal, irq_line
// cfg      | in  | cfg_index, cfg_data (prg_bank_count, four_screen)
//
// One transaction per cycle while the output is not stalled: an item is held in the input
// register, then translation and the register update land in the result register.
// A stalled result holds the input register; the input side stalls only then.
// Reset (rst_n, asynchronous) clears all mapper state; config goes to defaults.
`timescale 1ns / 1ps

module bank_switch_mapper_with_scanline_irq
    import bsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [18:0] rom_offset, [19] mirror_horizontal,
                                   // [20] irq_line, [23:21] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    item_t       item_reg;
    logic        in_valid_reg;
    logic        advance;
    map_view_t   view;
    logic        mirror_next;
    logic        irq_next;
    logic [18:0] rom_offset;
    logic [23:0] result_reg;
    logic        out_valid_reg;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            item_reg <= '{op: op_t'(s_tuser), address: s_tdata[15:0],
                          write_data: s_tdata[23:16]};
    end

    bsm_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .advance     (advance),
        .item        (item_reg),
        .view        (view),
        .mirror_next (mirror_next),
        .irq_next    (irq_next)
    );

    bsm_xlate u_xlate (
        .item       (item_reg),
        .view       (view),
        .rom_offset (rom_offset)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= {3'b000, irq_next, mirror_next, rom_offset};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

endmodule

// ----- design/bsm_checker.sv -----
// Port-level checks for the bank switch mapper, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module bsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Input stalls only behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // A result appearing on an empty output must follow an accepted input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without matching input transaction");

    // Padding bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:21] == 3'b000)
        else $error("result padding not zero");

endmodule

bind bank_switch_mapper_with_scanline_irq bsm_checker u_bsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/tb_bank_switch_mapper_with_scanline_irq.sv -----
// Testbench for bank_switch_mapper_with_scanline_irq: directed and random mapper traffic,
// predicted in-bench and checked per field at the result stream. Depends on bsm_pkg.
`timescale 1ns / 1ps

module tb_bank_switch_mapper_with_scanline_irq;
    import bsm_pkg::*;

    typedef struct {
        logic [18:0] rom_offset;
        logic        mirror_horizontal;
        logic        irq_line;
    } mapper_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;   // [1:0] op
    logic [23:0] s_tdata = '0;   // [15:0] address, [23:16] write_data
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [18:0] rom_offset, [19] mirror_horizontal, [20] irq_line
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [6:0]  cfg_data = '0;

    // Predicted mapper state
    logic [7:0] mp_bank [8] = '{default: 8'h00};
    logic [2:0] mp_select = '0;
    logic       mp_prg_inv = 1'b0;
    logic       mp_chr_inv = 1'b0;
    logic       mp_mirror = 1'b0;
    logic [7:0] mp_latch = '0;
    logic [7:0] mp_count = '0;
    logic       mp_reload = 1'b0;
    logic       mp_irq_en = 1'b0;
    logic       mp_irq = 1'b0;
    logic [6:0] mp_bank_count = PRG_BANK_COUNT_RESET;
    logic       mp_four_screen = 1'b0;

    mapper_out_t awaited_outputs[$];
    int          mismatches = 0;
    bit          source_gaps = 1'b1;
    bit          sink_stalls = 1'b1;
    int          sink_hold = 0;

    bank_switch_mapper_with_scanline_irq dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Apply one item to the predicted state and return the outputs it leaves
    function automatic mapper_out_t map_item(op_t op, logic [15:0] addr, logic [7:0] data);
        mapper_out_t r;
        logic [6:0]  n;
        logic [5:0]  prg_bank;
        logic [7:0]  chr_bank;
        logic [2:0]  slot;
        r.rom_offset = '0;
        n = mp_bank_count;
        if (n < PRG_BANK_COUNT_MIN)
            n = PRG_BANK_COUNT_MIN;
        if (n > PRG_BANK_COUNT_MAX)
            n = PRG_BANK_COUNT_MAX;
        case (op)
            OP_WRITE:
                if (addr[15])
                begin
                    case (addr[14:13])
                        WIN_SELECT:
                            if (!addr[0])
                            begin
                                mp_select  = data[2:0];
                                mp_prg_inv = data[6];
                                mp_chr_inv = data[7];
                            end
                            else
                                mp_bank[mp_select] = data;
                        WIN_MIRROR:
                            if (!addr[0] && !mp_four_screen)
                                mp_mirror = data[0];
                        WIN_LATCH:
                            if (!addr[0])
                                mp_latch = data;
                            else
                                mp_reload = 1'b1;
                        default:
                            if (!addr[0])
                            begin
                                mp_irq_en = 1'b0;
                                mp_irq    = 1'b0;
                            end
                            else
                                mp_irq_en = 1'b1;
                    endcase
                end
            OP_PRG:
                if (addr[15])
                begin
                    if (addr[14:13] == PRG_SLOT_LAST)
                        prg_bank = 6'(n - 7'd1);
                    else if (addr[14:13] == PRG_SLOT_R7)
                        prg_bank = mp_bank[7][5:0];
                    else if ((addr[14:13] == PRG_SLOT_ZERO) != mp_prg_inv)
                        prg_bank = mp_bank[6][5:0];
                    else
                        prg_bank = 6'(n - 7'd2);
                    r.rom_offset = {prg_bank, addr[12:0]};
                end
            OP_CHR:
            begin
                slot = addr[12:10] ^ {mp_chr_inv, 2'b00};
                // Lower four slots are 2 KB pairs, upper four single 1 KB slots
                if (!slot[2])
                    chr_bank = {mp_bank[slot[1]][7:1], slot[0]};
                else
                    chr_bank = mp_bank[slot - 3'd2];
                r.rom_offset = {1'b0, chr_bank, addr[9:0]};
            end
            default:
            begin
                if (mp_count == 8'd0 || mp_reload)
                begin
                    mp_count  = mp_latch;
                    mp_reload = 1'b0;
                end
                else
                    mp_count = mp_count - 8'd1;
                if (mp_count == 8'd0 && mp_irq_en)
                    mp_irq = 1'b1;
            end
        endcase
        r.mirror_horizontal = mp_mirror;
        r.irq_line          = mp_irq;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_item(op_t op, logic [15:0] addr, logic [7:0] data);
        int gap;
        gap = source_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {data, addr};
        do
            @(posedge clk);
        while (!s_tready);
        awaited_outputs.push_back(map_item(op, addr, data));
    endtask

    // Hold the input low until every result is back, then let the pipeline settle
    task automatic drain_mapper();
        s_tvalid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic [6:0] bank_count, logic four);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PRG_BANK_COUNT;
        cfg_data  <= bank_count;
        do
            @(posedge clk);
        while (!cfg_ready);
        mp_bank_count = bank_count;
        cfg_index <= CFG_FOUR_SCREEN;
        cfg_data  <= {6'd0, four};
        do
            @(posedge clk);
        while (!cfg_ready);
        mp_four_screen = four;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end
        else if (sink_stalls && $urandom_range(99) < 20)
        begin
            sink_hold <= pick_gap();
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_outputs
        mapper_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_outputs.size() == 0)
                report_mismatch($sformatf("unexpected result tdata=%h", m_tdata));
            else
            begin
                want = awaited_outputs.pop_front();
                if (m_tdata[18:0] !== want.rom_offset)
                    report_mismatch($sformatf("rom_offset %h, want %h",
                                              m_tdata[18:0], want.rom_offset));
                if (m_tdata[19] !== want.mirror_horizontal)
                    report_mismatch($sformatf("mirror_horizontal %b, want %b",
                                              m_tdata[19], want.mirror_horizontal));
                if (m_tdata[20] !== want.irq_line)
                    report_mismatch($sformatf("irq_line %b, want %b",
                                              m_tdata[20], want.irq_line));
            end
        end
    end

    task automatic test_register_writes();
        send_item(OP_WRITE, 16'h8000, 8'hC6);   // select R6, both inversions
        send_item(OP_WRITE, 16'h8001, 8'hFF);
        send_item(OP_WRITE, 16'h8000, 8'h07);
        send_item(OP_WRITE, 16'h9FFF, 8'h2A);
        send_item(OP_WRITE, 16'hA000, 8'h01);
        send_item(OP_WRITE, 16'hA001, 8'h00);   // protect register, ignored
        send_item(OP_WRITE, 16'h7FFE, 8'hC5);   // below the decoded range
    endtask

    task automatic test_prg_mapping();
        send_item(OP_PRG, 16'h8000, 8'h00);
        send_item(OP_PRG, 16'hBFFF, 8'h00);
        send_item(OP_PRG, 16'hDFFF, 8'h00);
        send_item(OP_PRG, 16'hFFFF, 8'h00);
        send_item(OP_WRITE, 16'h8000, 8'h40);
        send_item(OP_PRG, 16'h8123, 8'hFF);
        send_item(OP_PRG, 16'hC000, 8'h00);
        send_item(OP_PRG, 16'h7FFF, 8'h00);
    endtask

    task automatic test_chr_mapping();
        send_item(OP_WRITE, 16'h8001, 8'hFF);   // R0
        send_item(OP_CHR, 16'h0000, 8'h00);
        send_item(OP_CHR, 16'h07FF, 8'h00);
        send_item(OP_WRITE, 16'h8000, 8'h80);
        send_item(OP_CHR, 16'h1000, 8'h00);
        send_item(OP_CHR, 16'hFFFF, 8'h00);     // bits above the pattern space ignored
    endtask

    task automatic test_irq_counter();
        send_item(OP_WRITE, 16'hC000, 8'h01);
        send_item(OP_WRITE, 16'hC001, 8'h00);
        send_item(OP_WRITE, 16'hE001, 8'h00);
        repeat (3) send_item(OP_TICK, 16'h0000, 8'h00);
        send_item(OP_WRITE, 16'hE000, 8'h00);   // disable drops the line
    endtask

    task automatic test_bank_count_limits();
        drain_mapper();
        set_config(7'd0, 1'b1);
        send_item(OP_PRG, 16'hE000, 8'h00);
        send_item(OP_WRITE, 16'hA000, 8'h00);   // four-screen keeps mirroring
        drain_mapper();
        set_config(7'd127, 1'b0);
        send_item(OP_PRG, 16'hFFFF, 8'h00);
        send_item(OP_WRITE, 16'hBFFE, 8'h00);
    endtask

    task automatic send_irq_sequence(output int count);
        int ticks;
        send_item(OP_WRITE, {3'b110, 12'($urandom), 1'b0},
                  ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)));
        send_item(OP_WRITE, {3'b110, 12'($urandom), 1'b1}, 8'($urandom));
        send_item(OP_WRITE, {3'b111, 12'($urandom), 1'b1}, 8'($urandom));
        ticks = $urandom_range(1, 10);
        repeat (ticks) send_item(OP_TICK, 16'($urandom), 8'($urandom));
        count = 3 + ticks;
        if ($urandom_range(9) < 3)
        begin
            send_item(OP_WRITE, {3'b111, 12'($urandom), 1'b0}, 8'($urandom));
            count++;
        end
    endtask

    task automatic send_random_item();
        op_t         op;
        logic [15:0] addr;
        logic [7:0]  data;
        int          r;
        r = $urandom_range(99);
        op = (r < 35) ? OP_WRITE : (r < 55) ? OP_PRG : (r < 75) ? OP_CHR : OP_TICK;
        addr = 16'($urandom);
        // Keep most CPU-side accesses in the mapper window
        if (op != OP_CHR && $urandom_range(9) != 0)
            addr[15] = 1'b1;
        data = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 4)) : 8'($urandom);
        send_item(op, addr, data);
    endtask

    task automatic test_random_traffic(logic [6:0] bank_count, logic four,
                                       bit gaps, bit stalls, int items);
        int sent;
        int seq_items;
        drain_mapper();
        set_config(bank_count, four);
        source_gaps = gaps;
        sink_stalls = stalls;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_irq_sequence(seq_items);
                sent += seq_items;
            end
            else
            begin
                send_random_item();
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_writes();
        test_prg_mapping();
        test_chr_mapping();
        test_irq_counter();
        test_bank_count_limits();
        test_random_traffic(7'd2, 1'b1, 1'b1, 1'b1, 110);
        test_random_traffic(7'd64, 1'b0, 1'b0, 1'b0, 110);
        test_random_traffic(7'd1, 1'b0, 1'b1, 1'b0, 110);
        test_random_traffic(7'd127, 1'b1, 1'b0, 1'b1, 110);
        test_random_traffic(7'($urandom), 1'($urandom), 1'b1, 1'b1, 110);
        drain_mapper();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
